// File: rtl/npr_pkg.sv
package npr_pkg;

   localparam int TYPE_W   = 2;
   localparam int NAME_W   = 64;
   localparam int OWNER_W  = 32;
   localparam int STATUS_W = 2;

   localparam logic [TYPE_W-1:0] OP_REGISTER   = 2'd0;
   localparam logic [TYPE_W-1:0] OP_UNREGISTER = 2'd1;
   localparam logic [TYPE_W-1:0] OP_LOOKUP     = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_REPLY
   } npr_state_type;

   // Request held steady for all cells while an item is being worked on.
   typedef struct packed {
      logic [TYPE_W-1:0]  op;
      logic [NAME_W-1:0]  name;
      logic [OWNER_W-1:0] owner;
   } npr_cmd_type;

   // Token handed from cell to cell during a sweep.
   typedef struct packed {
      logic               valid;
      logic               fill;
      logic               done;
      logic               free_seen;
      logic [OWNER_W-1:0] owner;
   } npr_carry_type;

endpackage

// File: rtl/npr_if.sv
interface npr_req_if;
   import npr_pkg::*;

   logic               valid;
   logic               ready;
   logic [TYPE_W-1:0]  req_type;
   logic [NAME_W-1:0]  port_name;
   logic [OWNER_W-1:0] owner_id;

   modport source (output valid, output req_type, output port_name, output owner_id,
                   input ready);
   modport sink   (input valid, input req_type, input port_name, input owner_id,
                   output ready);
endinterface

interface npr_rsp_if;
   import npr_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [OWNER_W-1:0]  found_owner;

   modport source (output valid, output status, output found_owner, input ready);
   modport sink   (input valid, input status, input found_owner, output ready);
endinterface

// File: rtl/npr_cell.sv
module npr_cell #(
   parameter int NAME_CHARS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  npr_pkg::npr_cmd_type   cmd,
   input  npr_pkg::npr_carry_type carry_prev,
   output npr_pkg::npr_carry_type carry_next
);
   import npr_pkg::*;

   localparam int NAME_BITS = 8 * NAME_CHARS;

   logic                 valid_ff, valid_in;
   logic [NAME_BITS-1:0] name_ff, name_in;
   logic [OWNER_W-1:0]   owner_ff, owner_in;
   npr_carry_type        carry_ff, carry_in;

   logic owner_hit;
   logic name_hit;

   assign owner_hit = valid_ff && (owner_ff == cmd.owner);
   assign name_hit  = valid_ff && (name_ff == cmd.name[NAME_BITS-1:0]);

   always_comb begin
      valid_in = valid_ff;
      name_in  = name_ff;
      owner_in = owner_ff;
      carry_in = carry_prev;
      if (carry_prev.valid) begin
         case (cmd.op)
            OP_REGISTER: begin
               if (!carry_prev.fill) begin
                  // First pass: rename the owner's entry and note any free slot.
                  if (!carry_prev.done && owner_hit) begin
                     name_in       = cmd.name[NAME_BITS-1:0];
                     carry_in.done = 1'b1;
                  end
                  if (!valid_ff) begin
                     carry_in.free_seen = 1'b1;
                  end
               end else if (!carry_prev.done && !valid_ff) begin
                  valid_in      = 1'b1;
                  name_in       = cmd.name[NAME_BITS-1:0];
                  owner_in      = cmd.owner;
                  carry_in.done = 1'b1;
               end
            end
            OP_UNREGISTER: begin
               if (owner_hit) begin
                  valid_in = 1'b0;
               end
            end
            OP_LOOKUP: begin
               if (!carry_prev.done && name_hit) begin
                  carry_in.owner = owner_ff;
                  carry_in.done  = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         carry_ff.valid <= 1'b0;
      end else begin
         valid_ff       <= valid_in;
         carry_ff.valid <= carry_in.valid;
      end
      name_ff            <= name_in;
      owner_ff           <= owner_in;
      carry_ff.fill      <= carry_in.fill;
      carry_ff.done      <= carry_in.done;
      carry_ff.free_seen <= carry_in.free_seen;
      carry_ff.owner     <= carry_in.owner;
   end

   assign carry_next = carry_ff;

endmodule

// File: rtl/npr_ctrl.sv
module npr_ctrl #(
   parameter int NAME_CHARS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   npr_req_if.sink                req_chan,
   npr_rsp_if.source              rsp_chan,
   output npr_pkg::npr_cmd_type   cmd,
   output npr_pkg::npr_carry_type launch,
   input  npr_pkg::npr_carry_type sweep_ret
);
   import npr_pkg::*;

   npr_state_type        state_ff, state_in;
   npr_cmd_type          cmd_ff, cmd_in;
   npr_carry_type        launch_ff, launch_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [OWNER_W-1:0]   found_ff, found_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [OWNER_W-1:0]   rsp_owner_ff, rsp_owner_in;

   logic                 req_xfer;
   logic                 rsp_free;
   logic [NAME_W-1:0]    name_cut;
   logic                 req_sweep;
   logic [STATUS_W-1:0]  req_status;
   logic                 need_fill;

   function automatic logic [NAME_W-1:0] cut_name(input logic [NAME_W-1:0] raw);
      logic [NAME_W-1:0] kept;
      logic              live;
      kept = '0;
      live = 1'b1;
      for (int i = 0; i < NAME_CHARS; i++) begin
         if (raw[8*i +: 8] == 8'd0) begin
            live = 1'b0;
         end
         if (live) begin
            kept[8*i +: 8] = raw[8*i +: 8];
         end
      end
      return kept;
   endfunction

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign name_cut       = cut_name(req_chan.port_name);
   assign need_fill      = (cmd_ff.op == OP_REGISTER) && !sweep_ret.fill
                           && !sweep_ret.done && sweep_ret.free_seen;

   // Requests that need no table sweep are answered straight away.
   always_comb begin
      req_sweep  = 1'b0;
      req_status = STATUS_INVALID;
      case (req_chan.req_type)
         OP_REGISTER: begin
            req_sweep = (name_cut != '0) && (req_chan.owner_id != '0);
         end
         OP_UNREGISTER: begin
            req_sweep  = (req_chan.owner_id != '0);
            req_status = STATUS_OK;
         end
         OP_LOOKUP: begin
            req_sweep = (name_cut != '0);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = req_sweep ? ST_SWEEP : ST_REPLY;
            end
         end
         ST_SWEEP: begin
            if (sweep_ret.valid && !need_fill) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd_in        = cmd_ff;
      launch_in     = '0;
      status_in     = status_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_owner_in  = rsp_owner_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cmd_in.op       = req_chan.req_type;
               cmd_in.name     = name_cut;
               cmd_in.owner    = req_chan.owner_id;
               launch_in.valid = req_sweep;
               status_in       = req_status;
               found_in        = '0;
            end
         end
         ST_SWEEP: begin
            if (sweep_ret.valid) begin
               if (need_fill) begin
                  // No entry of this owner exists: sweep again to claim a free slot.
                  launch_in.valid = 1'b1;
                  launch_in.fill  = 1'b1;
               end else begin
                  found_in  = '0;
                  status_in = STATUS_OK;
                  case (cmd_ff.op)
                     OP_REGISTER: begin
                        if (!sweep_ret.done) begin
                           status_in = STATUS_FULL;
                        end
                     end
                     OP_LOOKUP: begin
                        if (sweep_ret.done) begin
                           found_in = sweep_ret.owner;
                        end else begin
                           status_in = STATUS_NOT_FOUND;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         ST_REPLY: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_owner_in  = found_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         launch_ff.valid <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         launch_ff.valid <= launch_in.valid;
         rsp_valid_ff    <= rsp_valid_in;
      end
      launch_ff.fill      <= launch_in.fill;
      launch_ff.done      <= launch_in.done;
      launch_ff.free_seen <= launch_in.free_seen;
      launch_ff.owner     <= launch_in.owner;
      cmd_ff              <= cmd_in;
      status_ff           <= status_in;
      found_ff            <= found_in;
      rsp_status_ff       <= rsp_status_in;
      rsp_owner_ff        <= rsp_owner_in;
   end

   assign cmd                  = cmd_ff;
   assign launch               = launch_ff;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.found_owner = rsp_owner_ff;

endmodule

// File: rtl/named_port_registry_cam_unit.sv
// A lookup, an unregister, a renaming register or a refused (table full) register
// sweeps the table once between request transfer and response valid; a register
// that claims a free entry sweeps twice. Requests answered without touching the
// table (invalid, owner 0 unregister) go straight to the reply state.
// One request in flight; the next transfer waits until the response is issued, and
// longer while an earlier response waits. Synchronous active-high reset clears the valid bits.
module named_port_registry_cam_unit #(
   parameter int TABLE_ENTRIES = 16,
   parameter int NAME_CHARS    = 8
) (
   input  logic      clock,
   input  logic      reset,
   npr_req_if.sink   req_chan,
   npr_rsp_if.source rsp_chan
);
   import npr_pkg::*;

   npr_cmd_type   cmd;
   npr_carry_type chain [TABLE_ENTRIES+1];

   npr_ctrl #(
      .NAME_CHARS (NAME_CHARS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .cmd       (cmd),
      .launch    (chain[0]),
      .sweep_ret (chain[TABLE_ENTRIES])
   );

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      npr_cell #(
         .NAME_CHARS (NAME_CHARS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .carry_prev (chain[g]),
         .carry_next (chain[g+1])
      );
   end

endmodule
